@@ rtl/vde_pkg.sv @@
// Shared types and constants for the vector distance engine.
// No dependencies; imported by vector_distance_engine_core.
package vde_pkg;

	// Fixed field and register widths
	localparam int LANE_COUNT = 4;
	localparam int SUM_W      = 44;
	localparam int DIST_W     = 43;
	localparam int VG_W       = 9;
	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W  = 1;

	typedef logic [SUM_W-1:0]         sum_t;
	typedef logic signed [DIST_W-1:0] dist_t;
	typedef logic [CFG_DATA_W-1:0]    cfg_data_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
	typedef logic [VG_W-1:0]          vgroups_t;

	// Register indexes
	localparam cfg_idx_t REG_METRIC = 1'd0;
	localparam cfg_idx_t REG_GROUPS = 1'd1;

	// Item modes
	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_COMPARE = 1'b1;

	// Metrics
	localparam logic METRIC_L2 = 1'b0;
	localparam logic METRIC_IP = 1'b1;

	localparam vgroups_t GROUPS_RESET = 9'd32;

endpackage

@@ rtl/vector_distance_engine_core.sv @@
// Vector distance engine: query store in vde_ram, three-stage datapath, output register.
// Depends on vde_pkg and vde_ram.
//
//   channel | signals                                  | flow
//   in      | in_valid, in_stall, mode, elem0..elem3   | into block
//   out     | out_valid, out_stall, distance           | out of block
//   cfg     | cfg_write, cfg_index, cfg_data           | into block, no handshake
//
// One item per cycle while in_stall is low. A compare item reads the query store at its
// accept edge; its row is read, multiplied, lane-summed and accumulated toward out_valid.
// Loads write the store at their accept edge. arst_n clears pointers, the running sum
// and all valid flags; the query store is not cleared. in_stall rises only while a
// finished distance sits in the output register under out_stall and another one is
// ready to leave the last stage; the whole datapath holds until it moves.
module vector_distance_engine_core #(
	parameter int MAX_GROUPS   = 256,
	parameter int ELEMENT_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  vde_pkg::cfg_idx_t           cfg_index,
	input  vde_pkg::cfg_data_t          cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic signed [ELEMENT_BITS-1:0] elem0,
	input  logic signed [ELEMENT_BITS-1:0] elem1,
	input  logic signed [ELEMENT_BITS-1:0] elem2,
	input  logic signed [ELEMENT_BITS-1:0] elem3,
	output logic                        out_valid,
	input  logic                        out_stall,
	output vde_pkg::dist_t              distance
);

	import vde_pkg::*;

	localparam int ADDR_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int CNT_W  = $clog2(MAX_GROUPS + 1);
	localparam int CMP_W  = (CNT_W > VG_W) ? CNT_W : VG_W;
	localparam int DIFF_W = ELEMENT_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int EXT_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;
	localparam int ROW_W  = LANE_COUNT * ELEMENT_BITS;

	typedef logic signed [ELEMENT_BITS-1:0] elem_t;
	typedef logic signed [DIFF_W-1:0]       diff_t;
	typedef logic signed [PROD_W-1:0]       prod_t;
	typedef logic [ADDR_W-1:0]              addr_t;
	typedef logic [CMP_W-1:0]               cmp_t;

	// Configuration
	logic     metric_q;
	vgroups_t vector_groups_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q        <= METRIC_L2;
			vector_groups_q <= GROUPS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_METRIC: metric_q        <= cfg_data[0];
				REG_GROUPS: vector_groups_q <= cfg_data[VG_W-1:0];
				default:    ;
			endcase
		end
	end

	// Effective group count, clamped to 1..MAX_GROUPS
	cmp_t groups;
	always_comb begin
		priority if (vector_groups_q == '0) begin
			groups = cmp_t'(1);
		end else if (cmp_t'(vector_groups_q) > cmp_t'(MAX_GROUPS)) begin
			groups = cmp_t'(MAX_GROUPS);
		end else begin
			groups = cmp_t'(vector_groups_q);
		end
	end

	// Flow control
	logic  adv;
	logic  in_accept;
	logic  v_s1, v_s2, v_s3;
	logic  last_s1, last_s2, last_s3;
	logic  metric_s1, metric_s2;
	logic  out_valid_q;
	dist_t distance_q;

	assign adv       = !(v_s3 && last_s3 && out_valid_q && out_stall);
	assign in_stall  = !adv;
	assign in_accept = in_valid && adv;

	logic is_load, is_cmp;
	assign is_load = in_accept && (mode == MODE_LOAD);
	assign is_cmp  = in_accept && (mode == MODE_COMPARE);

	// Pointers
	addr_t load_ptr_q, cmp_ptr_q;
	cmp_t  load_next, cmp_next;
	logic  cmp_last;

	assign load_next = cmp_t'(load_ptr_q) + cmp_t'(1);
	assign cmp_next  = cmp_t'(cmp_ptr_q) + cmp_t'(1);
	assign cmp_last  = (cmp_next >= groups);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr_q <= '0;
			cmp_ptr_q  <= '0;
		end else begin
			if (is_load) begin
				load_ptr_q <= (load_next >= groups) ? '0 : load_next[ADDR_W-1:0];
			end
			if (is_cmp) begin
				cmp_ptr_q <= cmp_last ? '0 : cmp_next[ADDR_W-1:0];
			end
		end
	end

	// Query store
	elem_t            lane_in [LANE_COUNT];
	logic [ROW_W-1:0] wr_row;
	logic [ROW_W-1:0] rd_row;

	assign lane_in[0] = elem0;
	assign lane_in[1] = elem1;
	assign lane_in[2] = elem2;
	assign lane_in[3] = elem3;

	always_comb begin
		for (int l = 0; l < LANE_COUNT; l++) begin
			wr_row[l*ELEMENT_BITS +: ELEMENT_BITS] = lane_in[l];
		end
	end

	vde_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_GROUPS)
	) u_query_ram (
		.clk     (clk),
		.wr_en   (is_load),
		.wr_addr (load_ptr_q),
		.wr_data (wr_row),
		.rd_en   (is_cmp),
		.rd_addr (cmp_ptr_q),
		.rd_data (rd_row)
	);

	// Stage 1: lanes wait for the store row
	elem_t lane_s1 [LANE_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= is_cmp;
		end
	end

	always_ff @(posedge clk) begin
		if (is_cmp) begin
			last_s1   <= cmp_last;
			metric_s1 <= metric_q;
			lane_s1   <= lane_in;
		end
	end

	// Difference or pass-through, then one multiply per lane
	prod_t prod [LANE_COUNT];
	always_comb begin
		diff_t a, b, q, x;
		for (int l = 0; l < LANE_COUNT; l++) begin
			x = diff_t'(lane_s1[l]);
			q = diff_t'(elem_t'(rd_row[l*ELEMENT_BITS +: ELEMENT_BITS]));
			a = (metric_s1 == METRIC_IP) ? x : (x - q);
			b = (metric_s1 == METRIC_IP) ? q : (x - q);
			prod[l] = prod_t'(a) * prod_t'(b);
		end
	end

	// Stage 2: products
	prod_t prod_s2 [LANE_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2   <= last_s1;
			metric_s2 <= metric_s1;
			prod_s2   <= prod;
		end
	end

	// Lane sum, wrapped to the accumulator width
	sum_t lane_sum;
	always_comb begin
		logic signed [EXT_W-1:0] pe;
		lane_sum = '0;
		for (int l = 0; l < LANE_COUNT; l++) begin
			pe       = EXT_W'(prod_s2[l]);
			lane_sum = lane_sum + pe[SUM_W-1:0];
		end
	end

	// Stage 3: group sum
	sum_t part_s3;
	logic metric_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s3   <= last_s2;
			metric_s3 <= metric_s2;
			part_s3   <= lane_sum;
		end
	end

	// Accumulate and finish
	sum_t running_sum_q;
	sum_t total;
	sum_t result;

	assign total  = running_sum_q + part_s3;
	assign result = (metric_s3 == METRIC_IP) ? (sum_t'(0) - total) : total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (adv && v_s3) begin
				running_sum_q <= last_s3 ? '0 : total;
			end
			if (adv && v_s3 && last_s3) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3 && last_s3) begin
			distance_q <= dist_t'(result[DIST_W-1:0]);
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = distance_q;

	// Datapath holds only behind a blocked output
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> (out_valid_q && out_stall))
		else $error("datapath held without a blocked output");

	// A finishing compare rewinds the compare pointer
	assert property (@(posedge clk) disable iff (!arst_n)
		(is_cmp && cmp_last) |=> (cmp_ptr_q == '0))
		else $error("compare pointer not rewound after last group");

	// A result appears only from a finishing group
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s3 && last_s3 && adv))
		else $error("result without a finishing group");

	// The running sum clears once a vector finishes
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s3 && last_s3) |=> (running_sum_q == '0))
		else $error("running sum not cleared after a result");

endmodule

@@ rtl/vde_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used by vector_distance_engine_core for the query store.
module vde_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic                                        rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
